[hw/rtl/can_id_latest_value_table_top_macros.svh]
// assertion macros for the can id latest-value table
// used by can_id_latest_value_table_top, needs no other file
`ifndef CAN_ID_LATEST_VALUE_TABLE_TOP_MACROS_SVH
`define CAN_ID_LATEST_VALUE_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CILVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CILVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cilvt_pkg.sv]
// shared types, constants and helpers of the can id latest-value table
// no dependencies; used by the interfaces and all modules
`default_nettype none

package cilvt_pkg;

  localparam int unsigned TableEntriesDef = 32;
  localparam int unsigned BurstFramesDef  = 16;

  localparam int unsigned IdW   = 11;
  localparam int unsigned LenW  = 4;
  localparam int unsigned DataW = 64;

  localparam logic [IdW-1:0]  BootIdRst = 11'd176;
  localparam logic [LenW-1:0] MaxLen    = 4'd8;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_BOOT  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // one table entry as it travels along the ring
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] payload;
  } entry_t;

  // ring control from the controller to the cells
  typedef struct packed {
    logic   shift;
    entry_t tail;
  } shift_t;

  // controller status for checks at the top level
  typedef struct packed {
    logic idle;
    logic flushing;
  } status_t;

  // saturate the length code at eight bytes
  function automatic logic [LenW-1:0] sat_len(input logic [LenW-1:0] len);
    sat_len = (len > MaxLen) ? MaxLen : len;
  endfunction

  // mask covering the low len bytes of a payload
  function automatic logic [DataW-1:0] byte_mask(input logic [LenW-1:0] len);
    logic [DataW-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (LenW'(b) < len) begin
        m[8*b +: 8] = 8'hff;
      end
    end
    byte_mask = m;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cilvt_in_if.sv]
// input channel: received frames and flush commands
// depends on cilvt_pkg
`default_nettype none

interface cilvt_in_if;
  import cilvt_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic              extended_id;
  logic [IdW-1:0]    can_id;
  logic [LenW-1:0]   frame_length;
  logic [DataW-1:0]  payload;

  modport source (
    output valid, opcode, extended_id, can_id, frame_length, payload,
    input  ready
  );

  modport sink (
    input  valid, opcode, extended_id, can_id, frame_length, payload,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/cilvt_out_if.sv]
// output channel: table entries and bootloader reset requests
// depends on cilvt_pkg
`default_nettype none

interface cilvt_out_if;
  import cilvt_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [IdW-1:0]    out_id;
  logic [LenW-1:0]   out_length;
  logic [DataW-1:0]  out_payload;
  logic              group_end;
  logic              last;

  modport source (
    output valid, kind, out_id, out_length, out_payload, group_end, last,
    input  ready
  );

  modport sink (
    input  valid, kind, out_id, out_length, out_payload, group_end, last,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/cilvt_cell.sv]
// one storage cell of the entry ring; takes its neighbor's entry on shift
// depends on cilvt_pkg
`default_nettype none

module cilvt_cell (
  input  wire                    clk_i,
  input  cilvt_pkg::shift_t      ctrl_i,
  input  cilvt_pkg::entry_t      entry_i,
  output cilvt_pkg::entry_t      entry_o
);
  import cilvt_pkg::*;

  entry_t entry_q, entry_d;

  // hold or take the neighbor word
  always_comb begin
    entry_d = ctrl_i.shift ? entry_i : entry_q;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[hw/rtl/cilvt_ctrl.sv]
// controller: handshakes, ring stepping, head edit and output register
// depends on cilvt_pkg and the two channel interfaces
`default_nettype none

module cilvt_ctrl #(
  parameter int unsigned TableEntries = cilvt_pkg::TableEntriesDef,
  parameter int unsigned BurstFrames  = cilvt_pkg::BurstFramesDef,
  localparam int unsigned CntW        = $clog2(TableEntries + 1)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  cilvt_in_if.sink                    in_i,
  cilvt_out_if.source                 out_o,
  input  wire [cilvt_pkg::IdW-1:0]    boot_id_i,
  input  cilvt_pkg::entry_t           head_i,
  output cilvt_pkg::shift_t           ring_o,
  output cilvt_pkg::status_t          status_o,
  output logic [CntW-1:0]             count_o
);
  import cilvt_pkg::*;

  localparam int unsigned BurstW = $clog2(BurstFrames + 1);

  state_e state_q, state_d;

  logic [CntW-1:0]   count_q, step_q;
  logic [BurstW-1:0] burst_q;
  logic              found_q, ins_q;
  logic [IdW-1:0]    fid_q;
  logic [LenW-1:0]   flen_q;
  logic [DataW-1:0]  fdata_q, fmask_q;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [IdW-1:0]    out_id_q;
  logic [LenW-1:0]   out_len_q;
  logic [DataW-1:0]  out_data_q;
  logic              out_gend_q, out_last_q;

  logic out_free, accept, is_flush, is_boot, is_scan;
  logic last_step, live, hit, put, fin, group, step_en, emit;
  entry_t tail;

  // shared decode
  assign out_free  = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign is_flush  = (in_i.opcode == OP_FLUSH);
  assign is_boot   = !is_flush && !in_i.extended_id && (in_i.can_id == boot_id_i);
  assign is_scan   = !is_flush && !in_i.extended_id && (in_i.can_id != boot_id_i);
  assign last_step = (step_q == CntW'(TableEntries - 1));
  assign live      = (step_q < count_q);
  assign hit       = live && !found_q && (head_i.id == fid_q);
  assign put       = (step_q == count_q) && !found_q;
  assign fin       = (step_q == count_q - CntW'(1));
  assign group     = fin || (burst_q == BurstW'(BurstFrames - 1));

  // output and ring control
  always_comb begin
    in_i.ready = 1'b0;
    step_en    = 1'b0;
    emit       = 1'b0;
    tail       = head_i;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = out_free;
      end
      ST_SCAN: begin
        step_en = 1'b1;
        if (hit) begin
          tail.len     = flen_q;
          tail.payload = (head_i.payload & ~fmask_q) | fdata_q;
        end else if (put) begin
          tail.id      = fid_q;
          tail.len     = flen_q;
          tail.payload = fdata_q;
        end
      end
      ST_FLUSH: begin
        step_en = out_free;
        emit    = out_free;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_flush && (count_q != '0)) begin
          state_d = ST_FLUSH;
        end else if (accept && is_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (emit && fin) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      burst_q     <= '0;
      found_q     <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // output word: loaded by a reset request or a flush step, else drained
      if ((accept && is_boot) || emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        step_q  <= '0;
        burst_q <= '0;
        found_q <= 1'b0;
        ins_q   <= 1'b0;
        if (is_boot) begin
          count_q <= '0;
        end
      end
      if (state_q == ST_SCAN) begin
        step_q <= step_q + CntW'(1);
        if (hit) begin
          found_q <= 1'b1;
        end
        if (put) begin
          ins_q <= 1'b1;
        end
        if (last_step && (ins_q || put)) begin
          count_q <= count_q + CntW'(1);
        end
      end
      if (emit) begin
        step_q  <= step_q + CntW'(1);
        burst_q <= group ? '0 : burst_q + BurstW'(1);
        if (fin) begin
          count_q <= '0;
        end
      end
    end
  end

  // frame fields and output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fid_q   <= in_i.can_id;
      flen_q  <= sat_len(in_i.frame_length);
      fmask_q <= byte_mask(sat_len(in_i.frame_length));
      fdata_q <= in_i.payload & byte_mask(sat_len(in_i.frame_length));
      if (is_boot) begin
        out_kind_q <= KIND_BOOT;
        out_id_q   <= boot_id_i;
        out_len_q  <= '0;
        out_data_q <= '0;
        out_gend_q <= 1'b0;
        out_last_q <= 1'b1;
      end
    end
    if (emit) begin
      out_kind_q <= KIND_ENTRY;
      out_id_q   <= head_i.id;
      out_len_q  <= head_i.len;
      out_data_q <= head_i.payload;
      out_gend_q <= group;
      out_last_q <= fin;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.out_id      = out_id_q;
  assign out_o.out_length  = out_len_q;
  assign out_o.out_payload = out_data_q;
  assign out_o.group_end   = out_gend_q;
  assign out_o.last        = out_last_q;

  assign ring_o.shift      = step_en;
  assign ring_o.tail       = tail;
  assign status_o.idle     = (state_q == ST_IDLE);
  assign status_o.flushing = (state_q == ST_FLUSH);
  assign count_o           = count_q;

endmodule

`default_nettype wire

[hw/rtl/can_id_latest_value_table_top.sv]
// top level of the can id latest-value table: ring of cells, controller,
// bootloader id register; depends on cilvt_pkg, the interfaces, cilvt_cell, cilvt_ctrl
//
// Usage: in_i carries one word per received frame (opcode frame) or a flush
// command (opcode flush); out_o carries stored entries and reset requests.
// The table is a ring of TableEntries cells; the entry in cell 0 is the head.
// A standard frame is accepted and then takes one full turn of the ring,
// the head being matched, updated or filled once per cycle. Extended frames
// are absorbed in the accept cycle. A frame carrying the bootloader id
// empties the table and its reset request is valid in the cycle after
// acceptance. A flush emits one entry per cycle while the receiver takes
// them, in insertion order; group_end marks each BurstFrames-th entry and
// the final one. An empty flush gives nothing.
// A new word is taken only when the output register is empty or its word
// leaves in the same cycle, so a stalled result holds the input; a flush
// under a stalling receiver holds the ring and new words wait for the flush.
// Reset empties the table at once (no clearing pass) and loads the bootloader id
// with 176; cfg_we_i writes it, and the user must do so only between words: the block does not enforce it.
`default_nettype none

module can_id_latest_value_table_top #(
  parameter int unsigned TableEntries = cilvt_pkg::TableEntriesDef,
  parameter int unsigned BurstFrames  = cilvt_pkg::BurstFramesDef
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  cilvt_in_if.sink                    in_i,
  cilvt_out_if.source                 out_o,
  input  wire                         cfg_we_i,
  input  wire [cilvt_pkg::IdW-1:0]    cfg_wdata_i
);
  import cilvt_pkg::*;

  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic [IdW-1:0]  boot_q;
  shift_t          ring;
  status_t         status;
  logic [CntW-1:0] count;
  entry_t          cell_out [TableEntries];

  // bootloader id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_q <= BootIdRst;
    end else if (cfg_we_i) begin
      boot_q <= cfg_wdata_i;
    end
  end

  // controller
  cilvt_ctrl #(
    .TableEntries (TableEntries),
    .BurstFrames  (BurstFrames)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .boot_id_i (boot_q),
    .head_i    (cell_out[0]),
    .ring_o    (ring),
    .status_o  (status),
    .count_o   (count)
  );

  // ring of cells, each taking from its upper neighbor, the last from the edited head
  for (genvar k = 0; k < TableEntries; k++) begin : g_cell
    if (k == TableEntries - 1) begin : g_tail
      cilvt_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ring),
        .entry_i (ring.tail),
        .entry_o (cell_out[k])
      );
    end else begin : g_body
      cilvt_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ring),
        .entry_i (cell_out[k+1]),
        .entry_o (cell_out[k])
      );
    end
  end

  // checks
  `include "can_id_latest_value_table_top_macros.svh"

  `CILVT_ASSERT_IMPLY(a_ready_only_idle, clk_i, rst_ni, in_i.ready,
                      status.idle && !status.flushing, "input ready outside idle")
  `CILVT_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1,
                      count <= CntW'(TableEntries), "entry count above table size")
  `CILVT_ASSERT_IMPLY(a_boot_single, clk_i, rst_ni,
                      out_o.valid && (out_o.kind == KIND_BOOT),
                      out_o.last && !out_o.group_end && (out_o.out_length == '0),
                      "malformed reset request")
  `CILVT_ASSERT_NEXT(a_boot_clears, clk_i, rst_ni,
                     in_i.valid && in_i.ready && (in_i.opcode == OP_FRAME) &&
                     !in_i.extended_id && (in_i.can_id == boot_q),
                     out_o.valid && (count == '0), "bootloader frame did not clear table")

endmodule

`default_nettype wire
